>>> rtl/wavetable_note_oscillator_top_defines.svh
// Assertion macros for the wavetable note oscillator.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef WAVETABLE_NOTE_OSCILLATOR_TOP_DEFINES_SVH
`define WAVETABLE_NOTE_OSCILLATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WNO_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WNO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wno_pkg.sv
// Package for the wavetable note oscillator: field widths, defaults,
// sine table constants, configuration codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package wno_pkg;

  // Default geometry of the sine table and phase format.
  localparam int DEF_TABLE_DEPTH         = 4096;
  localparam int DEF_PHASE_FRACTION_BITS = 16;

  // Fixed field widths.
  localparam int STEP_W   = 28;
  localparam int VOLUME_W = 9;
  localparam int LENGTH_W = 24;
  localparam int SAMPLE_W = 32;
  localparam int RAMP_W   = 16;
  localparam int MAG_W    = SAMPLE_W - 1;

  localparam logic [RAMP_W-1:0]   DEF_RAMP_LENGTH = 16'd4410;
  localparam logic [LENGTH_W-1:0] POSITION_MAX    = '1;

  // Gain path widths: magnitude times volume, then times the ramp numerator.
  localparam int MV_W       = MAG_W + VOLUME_W;
  localparam int PROD_W     = MV_W + RAMP_W;
  localparam int VOL_SHIFT  = 8;
  localparam int QUOT_W     = PROD_W - VOL_SHIFT - RAMP_W;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_CYCLES = QUOT_W / DIV_STEPS;
  localparam int CNT_W      = $clog2(DIV_CYCLES);
  localparam int OUT16_SHIFT = 16;

  // Saturation bounds on the 33-bit signed intermediate.
  localparam logic [SAMPLE_W:0] SAT_POS     = 33'h0_7FFF_FFFF;
  localparam logic [SAMPLE_W:0] SAT_NEG_MAG = 33'h0_8000_0000;

  // Sine table generation constants (Q30).
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = PI_Q30 / 64'd2;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] FULL_SCALE  = 64'd2147483647;
  localparam int          TAYLOR_TERMS = 7;
  localparam logic [7:0]  TAYLOR_DIV [TAYLOR_TERMS] =
    '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUTPUT_MODE = 1'b0,
    CFG_RAMP_LENGTH = 1'b1
  } cfg_idx_t;

  // Item sequencer.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ADDR = 6'b000010,
    S_MUL1 = 6'b000100,
    S_MUL2 = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

endpackage

>>> rtl/wavetable_note_oscillator_top.sv
// Wavetable note oscillator: sine ROM lookup, volume and ramp gain, output register.
// Depends on wno_pkg and wavetable_note_oscillator_top_defines.svh.
`timescale 1ns / 1ps

// Usage:
// Each input item is one output-sample tick carrying note_start, phase_step,
// volume and note_length; each item yields exactly one result item with the
// sample and the step_error flag. Both channels use valid/stall; an item moves
// on an edge where valid is high and stall is low.
// The configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) is ready
// whenever reset is released; index 0 is output_mode, index 1 is ramp_length.
// Write it only while idle.
// Each item passes through the address stage and ROM read, the two gain
// multiplies and the gain divider, which resolves 4 of the 32 quotient bits per
// cycle. A new item is accepted only once the sequencer is back in idle.
// A finished result waits in the output register while out_stall is high; the
// next item may already be accepted and computed, and it then holds in its last
// state until the register frees up.
// Reset clears phase, note position and the sequencer, sets output_mode to 0 and
// ramp_length to 4410, and holds the input stalled and the configuration port
// not ready. The sine ROM is constant and needs no clearing.

`include "wavetable_note_oscillator_top_defines.svh"

module wavetable_note_oscillator_top
  import wno_pkg::*;
#(
  parameter int TABLE_DEPTH         = DEF_TABLE_DEPTH,
  parameter int PHASE_FRACTION_BITS = DEF_PHASE_FRACTION_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_note_start,
  input  logic [STEP_W-1:0]          in_phase_step,
  input  logic [VOLUME_W-1:0]        in_volume,
  input  logic [LENGTH_W-1:0]        in_note_length,
  // Result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_step_error,
  // Configuration port
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  localparam int ADDR_W    = $clog2(TABLE_DEPTH);
  localparam int PHASE_W   = ADDR_W + PHASE_FRACTION_BITS;
  localparam int SUM_W     = ((PHASE_W > STEP_W) ? PHASE_W : STEP_W) + 1;
  localparam int IDX_SUM_W = SUM_W + 1;

  // One table entry: quarter-wave Taylor sine in Q30, scaled to full scale.
  function automatic logic [SAMPLE_W-1:0] sine_entry(input int j);
    logic        neg;
    logic [63:0] jj;
    logic [63:0] a;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] mag;
    int          k;
    neg = (64'(j) * 64'd2) > 64'(TABLE_DEPTH);
    jj  = neg ? (64'(TABLE_DEPTH) - 64'(j)) : 64'(j);
    a   = (64'd2 * PI_Q30 * jj) / 64'(TABLE_DEPTH);
    if (a > PI_Q30) a = PI_Q30;
    if (a > HALF_PI_Q30) a = PI_Q30 - a;
    x2   = (a * a) >> 30;
    term = a;
    sum  = a;
    for (k = 0; k < TAYLOR_TERMS; k++) begin
      term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[k]);
      if ((k % 2) == 0) begin
        sum = (term > sum) ? 64'd0 : (sum - term);
      end else begin
        sum = sum + term;
      end
    end
    if (sum > ONE_Q30) sum = ONE_Q30;
    mag = (sum * FULL_SCALE) >> 30;
    return neg ? SAMPLE_W'(64'd0 - mag) : SAMPLE_W'(mag);
  endfunction

  // Configuration registers
  logic              mode_r;
  logic [RAMP_W-1:0] ramp_r;

  // Sequencer and note state
  state_t                state_r, state_nxt;
  logic [PHASE_W-1:0]    phase_r;
  logic [LENGTH_W-1:0]   pos_r;
  logic [CNT_W-1:0]      cnt_r;

  // Item registers
  logic                  start_r;
  logic [STEP_W-1:0]     step_r;
  logic [VOLUME_W-1:0]   vol_r;
  logic [LENGTH_W-1:0]   len_r;
  logic                  err_r;
  logic [RAMP_W-1:0]     num_r;
  logic [RAMP_W-1:0]     rdiv_r;
  logic                  neg_r;
  logic [MV_W-1:0]       mv_r;
  logic [RAMP_W-1:0]     rem_r, rem_nxt;
  logic [QUOT_W-1:0]     dq_r, dq_nxt;
  logic [SAMPLE_W-1:0]   rom_q_r;

  // Output register
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_step_error_r;

  // Sine ROM, read synchronously
  logic [SAMPLE_W-1:0] rom_tbl [TABLE_DEPTH];
  logic [ADDR_W-1:0]   rom_addr;

  for (genvar gj = 0; gj < TABLE_DEPTH; gj++) begin : g_rom
    localparam logic [SAMPLE_W-1:0] Entry = sine_entry(gj);
    assign rom_tbl[gj] = Entry;
  end

  always_ff @(posedge clk) begin
    rom_q_r <= rom_tbl[rom_addr];
  end

  // Handshake
  logic in_accept;
  logic out_free;
  logic out_load;

  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == S_DONE) && out_free;
  assign cfg_ready = rst_n;

  // Address stage: effective phase and position, table index, ramp numerator.
  logic [PHASE_W-1:0]   phase_eff;
  logic [LENGTH_W-1:0]  pos_eff;
  logic                 addr_err;
  logic [SUM_W-1:0]     phase_sum;
  logic [IDX_SUM_W-1:0] idx_sum;
  logic [RAMP_W-1:0]    r_eff;
  logic [LENGTH_W-1:0]  pos_m1;
  logic [LENGTH_W-1:0]  rel;
  logic [RAMP_W-1:0]    num_nxt;

  always_comb begin
    phase_eff = start_r ? '0 : phase_r;
    pos_eff   = start_r ? '0 : pos_r;
    addr_err  = (step_r >> PHASE_FRACTION_BITS) == '0;
    phase_sum = SUM_W'(phase_eff) + SUM_W'(step_r);
    idx_sum   = IDX_SUM_W'(phase_eff >> PHASE_FRACTION_BITS) +
                IDX_SUM_W'(phase_sum >> PHASE_FRACTION_BITS);
    rom_addr  = idx_sum[ADDR_W:1];

    r_eff  = (ramp_r == '0) ? RAMP_W'(1) : ramp_r;
    pos_m1 = pos_eff - LENGTH_W'(1);
    rel    = len_r - pos_m1;
    if (pos_eff == '0) begin
      num_nxt = '0;
    end else if (pos_m1 < LENGTH_W'(r_eff)) begin
      num_nxt = pos_m1[RAMP_W-1:0];
    end else if ((LENGTH_W + 1)'(pos_m1) + (LENGTH_W + 1)'(r_eff) <
                 (LENGTH_W + 1)'(len_r)) begin
      num_nxt = r_eff;
    end else if (len_r > pos_m1) begin
      num_nxt = (rel > LENGTH_W'(r_eff)) ? r_eff : rel[RAMP_W-1:0];
    end else begin
      num_nxt = '0;
    end
  end

  // Magnitude of the table value and the two gain products.
  logic [SAMPLE_W-1:0] rom_abs;
  logic [PROD_W-1:0]   prod;

  assign rom_abs = rom_q_r[SAMPLE_W-1] ? (~rom_q_r + SAMPLE_W'(1)) : rom_q_r;
  assign prod    = PROD_W'(mv_r) * PROD_W'(num_r);

  // Restoring divider, DIV_STEPS quotient bits per cycle.
  always_comb begin
    logic [RAMP_W:0] trial;
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial  = {rem_nxt, dq_nxt[QUOT_W-1]};
      dq_nxt = {dq_nxt[QUOT_W-2:0], 1'b0};
      if (trial >= {1'b0, rdiv_r}) begin
        trial     = trial - {1'b0, rdiv_r};
        dq_nxt[0] = 1'b1;
      end
      rem_nxt = trial[RAMP_W-1:0];
    end
  end

  // Saturation, sign and output format.
  logic [SAMPLE_W:0]        pos_lim;
  logic [SAMPLE_W:0]        neg_lim;
  logic signed [SAMPLE_W:0] x_full;
  logic signed [SAMPLE_W:0] x_shift;
  logic [SAMPLE_W-1:0]      sample_nxt;

  always_comb begin
    pos_lim = ({1'b0, dq_r} > SAT_POS) ? SAT_POS : {1'b0, dq_r};
    neg_lim = ({1'b0, dq_r} > SAT_NEG_MAG) ? SAT_NEG_MAG : {1'b0, dq_r};
    x_full  = neg_r ? -$signed(neg_lim) : $signed(pos_lim);
    x_shift = x_full >>> OUT16_SHIFT;
    if (err_r) begin
      sample_nxt = '0;
    end else if (mode_r) begin
      sample_nxt = x_full[SAMPLE_W-1:0];
    end else begin
      sample_nxt = x_shift[SAMPLE_W-1:0];
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_accept) state_nxt = S_ADDR;
      S_ADDR: state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_DIV;
      S_DIV:  if (cnt_r == CNT_W'(DIV_CYCLES - 1)) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state: sequencer, note state, configuration, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      mode_r      <= 1'b0;
      ramp_r      <= DEF_RAMP_LENGTH;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == S_ADDR) begin
        phase_r <= addr_err ? phase_eff : phase_sum[PHASE_W-1:0];
        if (addr_err || (pos_eff == POSITION_MAX)) begin
          pos_r <= pos_eff;
        end else begin
          pos_r <= pos_eff + LENGTH_W'(1);
        end
      end

      if (state_r == S_DIV) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else begin
        cnt_r <= '0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_OUTPUT_MODE: mode_r <= cfg_data[0];
          CFG_RAMP_LENGTH: ramp_r <= cfg_data[RAMP_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      start_r <= in_note_start;
      step_r  <= in_phase_step;
      vol_r   <= in_volume;
      len_r   <= in_note_length;
    end
    if (state_r == S_ADDR) begin
      err_r  <= addr_err;
      num_r  <= mode_r ? RAMP_W'(1) : num_nxt;
      rdiv_r <= mode_r ? RAMP_W'(1) : r_eff;
    end
    if (state_r == S_MUL1) begin
      neg_r <= rom_q_r[SAMPLE_W-1];
      mv_r  <= MV_W'(rom_abs[MAG_W-1:0]) * MV_W'(vol_r);
    end
    if (state_r == S_MUL2) begin
      rem_r <= prod[PROD_W-1 -: RAMP_W];
      dq_r  <= prod[VOL_SHIFT +: QUOT_W];
    end else if (state_r == S_DIV) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
    if (out_load) begin
      out_sample_r     <= $signed(sample_nxt);
      out_step_error_r <= err_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample     = out_sample_r;
  assign out_step_error = out_step_error_r;

  // Assertions
  `WNO_ASSERT_NEXT(a_hold_waiting_result, (state_r == S_DONE) && out_valid_r && out_stall, (state_r == S_DONE) && out_valid_r, "finished item overran a waiting result")
  `WNO_ASSERT_SAME(a_error_sample_zero, out_valid_r && out_step_error_r, out_sample_r == '0, "step error item carries a nonzero sample")
  `WNO_ASSERT_NEXT(a_error_holds_phase, (state_r == S_ADDR) && addr_err && !start_r, $stable(phase_r) && $stable(pos_r), "step error item advanced the note state")

endmodule
